/* design/lla_pkg.sv */
// Shared constants and types for the Life-like automaton row step unit.
`default_nettype none
package lla_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_BIRTH_MASK   = 2'd0;
	localparam logic [1:0] REG_SURVIVE_MASK = 2'd1;
	localparam logic [1:0] REG_COLUMNS      = 2'd2;

	// Register reset values
	localparam logic [8:0] BIRTH_MASK_RST   = 9'd8;
	localparam logic [8:0] SURVIVE_MASK_RST = 9'd12;
	localparam logic [6:0] COLUMNS_RST      = 7'd64;

	// Widths fixed by the stream words
	localparam int ROW_BITS  = 64;
	localparam int MASK_BITS = 9;
	localparam int COL_BITS  = 7;

	// Default grid width limit and job queue depth
	localparam int MAX_COLUMNS_DEF = 64;
	localparam int JOB_QUEUE_DEPTH = 4;

	// Job queue status seen by the front and back parts
	typedef struct packed {
		logic has_job;
		logic room_for_two;
	} lla_q_stat_t;

endpackage
`default_nettype wire

/* design/lla_queue.sv */
// Short job queue between front and back, up to two pushes and one pop a cycle.
`default_nettype none
module lla_queue #(
	parameter int WIDTH = 193,
	parameter int DEPTH = lla_pkg::JOB_QUEUE_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push0,
	input  wire logic [WIDTH-1:0]     data0,
	input  wire logic                 push1,
	input  wire logic [WIDTH-1:0]     data1,
	input  wire logic                 pop,
	output logic      [WIDTH-1:0]     head,
	output lla_pkg::lla_q_stat_t      stat
);
	import lla_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wptr_q;
	logic [PtrW-1:0]  rptr_q;
	logic [CntW-1:0]  count_q;
	logic [PtrW-1:0]  wptr_nx;

	// Wrap a pointer one place on
	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		logic [PtrW-1:0] r;
		if (p == PtrW'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PtrW'(1);
		end
		return r;
	endfunction

	assign wptr_nx = ptr_inc(wptr_q);

	// Hold job entries
	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wptr_q] <= data0;
		end
		if (push1) begin
			mem_q[wptr_nx] <= data1;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push0 && push1) begin
				wptr_q <= ptr_inc(wptr_nx);
			end else if (push0) begin
				wptr_q <= wptr_nx;
			end
			if (pop) begin
				rptr_q <= ptr_inc(rptr_q);
			end
			count_q <= count_q + CntW'(push0) + CntW'(push1) - CntW'(pop);
		end
	end

	assign head              = mem_q[rptr_q];
	assign stat.has_job      = (count_q != '0);
	assign stat.room_for_two = (count_q <= CntW'(DEPTH - 2));

endmodule
`default_nettype wire

/* design/lla_front.sv */
// Front part: takes rows, keeps the row window and issues evolve jobs.
`default_nettype none
module lla_front #(
	parameter int MAX_COLUMNS = lla_pkg::MAX_COLUMNS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [lla_pkg::ROW_BITS-1:0] in_row,
	input  wire logic                         in_last,
	input  wire logic [MAX_COLUMNS-1:0]       width_mask,
	input  lla_pkg::lla_q_stat_t              q_stat,
	output logic                              push0,
	output logic [3*MAX_COLUMNS:0]            job0,
	output logic                              push1,
	output logic [3*MAX_COLUMNS:0]            job1
);
	import lla_pkg::*;

	logic [MAX_COLUMNS-1:0] row_above_q;
	logic [MAX_COLUMNS-1:0] row_held_q;
	logic                   pending_q;
	logic                   fire;
	logic [MAX_COLUMNS-1:0] row;
	logic [3*MAX_COLUMNS:0] job_mid;
	logic [3*MAX_COLUMNS:0] job_end;

	assign in_ready = q_stat.room_for_two;
	assign fire     = in_valid && in_ready;
	assign row      = in_row[MAX_COLUMNS-1:0] & width_mask;

	// Job word: {last, down, mid, up}
	assign job_mid = {1'b0, row, row_held_q, row_above_q};
	assign job_end = {1'b1, {MAX_COLUMNS{1'b0}}, row,
		pending_q ? row_held_q : {MAX_COLUMNS{1'b0}}};

	// Classify the word: held row completes, and a bottom row closes the frame
	assign push0 = fire && (pending_q || in_last);
	assign job0  = pending_q ? job_mid : job_end;
	assign push1 = fire && pending_q && in_last;
	assign job1  = job_end;

	// Slide the row window, clear it after the bottom row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_above_q <= '0;
			row_held_q  <= '0;
			pending_q   <= 1'b0;
		end else if (fire) begin
			if (in_last) begin
				row_above_q <= '0;
				row_held_q  <= '0;
				pending_q   <= 1'b0;
			end else begin
				row_above_q <= pending_q ? row_held_q : '0;
				row_held_q  <= row;
				pending_q   <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* design/lla_back.sv */
// Back part: evolves one row per cycle unless the output stalls, and drives the output register.
`default_nettype none
module lla_back #(
	parameter int MAX_COLUMNS = lla_pkg::MAX_COLUMNS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  lla_pkg::lla_q_stat_t               q_stat,
	input  wire logic [3*MAX_COLUMNS:0]        job,
	output logic                               pop,
	input  wire logic [lla_pkg::MASK_BITS-1:0] birth_mask,
	input  wire logic [lla_pkg::MASK_BITS-1:0] survive_mask,
	input  wire logic [MAX_COLUMNS-1:0]        width_mask,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [MAX_COLUMNS-1:0]             next_row,
	output logic                               last_of_frame,
	output logic                               frame_alive
);
	import lla_pkg::*;

	logic [MAX_COLUMNS-1:0] up;
	logic [MAX_COLUMNS-1:0] mid;
	logic [MAX_COLUMNS-1:0] down;
	logic                   job_last;
	logic [MAX_COLUMNS+1:0] up_x;
	logic [MAX_COLUMNS+1:0] mid_x;
	logic [MAX_COLUMNS+1:0] down_x;
	logic [MAX_COLUMNS-1:0] nx;
	logic                   nx_live;
	logic                   valid_q;
	logic [MAX_COLUMNS-1:0] row_q;
	logic                   last_q;
	logic                   alive_q;
	logic                   any_live_q;

	// Drop cells outside the current grid width
	assign up       = job[MAX_COLUMNS-1:0] & width_mask;
	assign mid      = job[2*MAX_COLUMNS-1:MAX_COLUMNS] & width_mask;
	assign down     = job[3*MAX_COLUMNS-1:2*MAX_COLUMNS] & width_mask;
	assign job_last = job[3*MAX_COLUMNS];

	// Pad with dead cells at both edges
	assign up_x   = {1'b0, up, 1'b0};
	assign mid_x  = {1'b0, mid, 1'b0};
	assign down_x = {1'b0, down, 1'b0};

	// Count neighbours per column and apply the birth and survival masks
	always_comb begin
		logic [3:0] n;
		for (int i = 0; i < MAX_COLUMNS; i++) begin
			n = 4'(up_x[i]) + 4'(up_x[i+1]) + 4'(up_x[i+2])
				+ 4'(mid_x[i]) + 4'(mid_x[i+2])
				+ 4'(down_x[i]) + 4'(down_x[i+1]) + 4'(down_x[i+2]);
			if (mid[i]) begin
				nx[i] = survive_mask[n] & width_mask[i];
			end else begin
				nx[i] = (n != 4'd0) & birth_mask[n] & width_mask[i];
			end
		end
	end

	assign nx_live = |nx;
	assign pop     = q_stat.has_job && (!valid_q || out_ready);

	// Load the output register, track live cells over the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			any_live_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
				if (job_last) begin
					any_live_q <= 1'b0;
				end else begin
					any_live_q <= any_live_q | nx_live;
				end
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			row_q   <= nx;
			last_q  <= job_last;
			alive_q <= job_last & (any_live_q | nx_live);
		end
	end

	assign out_valid     = valid_q;
	assign next_row      = row_q;
	assign last_of_frame = last_q;
	assign frame_alive   = alive_q;

endmodule
`default_nettype wire

/* design/life_like_automaton_step_unit.sv */
// Top level of the Life-like automaton row step unit with its register file.
//
// Channel   Dir  Handshake                 Word
// s_axis    in   s_axis_tvalid/tready      tdata row_cells, tlast last_row
// m_axis    out  m_axis_tvalid/tready      tdata next_row, tlast last_of_frame,
//                                          tuser frame_alive
// cfg       in   cfg_valid/cfg_ready       cfg_index register, cfg_data value
//
// One row word per cycle; a row's result is evolved once the row below it is
// taken and leaves through the output register, and the bottom row of a frame
// that holds two or more rows yields two results, so a frame of R rows gives
// R result words. The back part's 64 parallel neighbour counters set the rate.
// Reset clears the row window and queue; no clearing pass.
// The input stalls only when the job queue lacks room for two jobs.
`default_nettype none
module life_like_automaton_step_unit #(
	parameter int MAX_COLUMNS = lla_pkg::MAX_COLUMNS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [lla_pkg::ROW_BITS-1:0]  s_axis_tdata,  // [63:0] row_cells
	input  wire logic                          s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [lla_pkg::ROW_BITS-1:0]       m_axis_tdata,  // [63:0] next_row
	output logic                               m_axis_tlast,
	output logic                               m_axis_tuser,  // [0] frame_alive
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [lla_pkg::MASK_BITS-1:0] cfg_data
);
	import lla_pkg::*;

	localparam int JobW = 3 * MAX_COLUMNS + 1;

	logic [MASK_BITS-1:0]   birth_q;
	logic [MASK_BITS-1:0]   survive_q;
	logic [COL_BITS-1:0]    columns_q;
	logic [MAX_COLUMNS-1:0] width_mask;
	lla_q_stat_t            q_stat;
	logic                   push0;
	logic                   push1;
	logic [JobW-1:0]        job0;
	logic [JobW-1:0]        job1;
	logic [JobW-1:0]        head;
	logic                   pop;
	logic [MAX_COLUMNS-1:0] next_row;

	assign cfg_ready = 1'b1;

	// Register file writes; unused index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			birth_q   <= BIRTH_MASK_RST;
			survive_q <= SURVIVE_MASK_RST;
			columns_q <= COLUMNS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BIRTH_MASK:   birth_q   <= cfg_data;
				REG_SURVIVE_MASK: survive_q <= cfg_data;
				REG_COLUMNS:      columns_q <= cfg_data[COL_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Columns in use; widths past the limit clamp naturally
	always_comb begin
		for (int i = 0; i < MAX_COLUMNS; i++) begin
			width_mask[i] = (columns_q > COL_BITS'(i));
		end
	end

	lla_front #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_row    (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.width_mask(width_mask),
		.q_stat    (q_stat),
		.push0     (push0),
		.job0      (job0),
		.push1     (push1),
		.job1      (job1)
	);

	lla_queue #(
		.WIDTH(JobW),
		.DEPTH(JOB_QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push0 (push0),
		.data0 (job0),
		.push1 (push1),
		.data1 (job1),
		.pop   (pop),
		.head  (head),
		.stat  (q_stat)
	);

	lla_back #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.job          (head),
		.pop          (pop),
		.birth_mask   (birth_q),
		.survive_mask (survive_q),
		.width_mask   (width_mask),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.next_row     (next_row),
		.last_of_frame(m_axis_tlast),
		.frame_alive  (m_axis_tuser)
	);

	assign m_axis_tdata = ROW_BITS'(next_row);

endmodule
`default_nettype wire

/* tb/sv/lla_step_checker.sv */
// Watches the row, result and register channels and checks each result word.
module lla_step_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	input  wire logic                          s_axis_tready,
	input  wire logic [lla_pkg::ROW_BITS-1:0]  s_axis_tdata,  // [63:0] row_cells
	input  wire logic                          s_axis_tlast,
	input  wire logic                          m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	input  wire logic [lla_pkg::ROW_BITS-1:0]  m_axis_tdata,  // [63:0] next_row
	input  wire logic                          m_axis_tlast,
	input  wire logic                          m_axis_tuser,  // [0] frame_alive
	input  wire logic                          cfg_valid,
	input  wire logic                          cfg_ready,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [lla_pkg::MASK_BITS-1:0] cfg_data,
	output int                                 fail_count,
	output int                                 pending
);
	import lla_pkg::*;

	localparam int SHOW_LIMIT = 30;

	typedef struct packed {
		logic [ROW_BITS-1:0] next_row;
		logic                last_of_frame;
		logic                frame_alive;
	} gen_row_t;

	// Next-generation rows still owed by the block, oldest first
	gen_row_t expected_rows[$];

	// Local copy of the registers and the row window
	logic [MASK_BITS-1:0] birth_mask    = BIRTH_MASK_RST;
	logic [MASK_BITS-1:0] survive_mask  = SURVIVE_MASK_RST;
	logic [COL_BITS-1:0]  columns       = COLUMNS_RST;
	logic [ROW_BITS-1:0]  row_above     = '0;
	logic [ROW_BITS-1:0]  row_held      = '0;
	logic                 row_pending   = 1'b0;
	logic                 any_live_seen = 1'b0;
	int                   shown         = 0;

	// Columns inside the grid; widths above the limit act as the limit
	function automatic logic [ROW_BITS-1:0] grid_mask();
		int w;
		w = (int'(columns) > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : int'(columns);
		return {ROW_BITS{1'b1}} >> (ROW_BITS - w);
	endfunction

	// Birth and survival rule applied to the middle of three rows
	function automatic logic [ROW_BITS-1:0] next_generation(input logic [ROW_BITS-1:0] up,
			input logic [ROW_BITS-1:0] mid, input logic [ROW_BITS-1:0] down);
		logic [ROW_BITS-1:0] wm;
		logic [ROW_BITS-1:0] nxt;
		int                  n;
		int                  c;
		int                  i;
		int                  d;
		wm = grid_mask();
		up &= wm;
		mid &= wm;
		down &= wm;
		nxt = '0;
		for (i = 0; i < ROW_BITS; i++) begin
			n = 0;
			for (d = -1; d <= 1; d++) begin
				c = i + d;
				if (c >= 0 && c < ROW_BITS) begin
					n += int'(up[c]) + int'(down[c]);
					if (d != 0) n += int'(mid[c]);
				end
			end
			if (mid[i]) nxt[i] = survive_mask[n];
			else nxt[i] = (n >= 1) && birth_mask[n];
		end
		return nxt & wm;
	endfunction

	// Advance the row window by one accepted row and queue the rows it completes
	task automatic take_row(input logic [ROW_BITS-1:0] row_in, input logic last);
		logic [ROW_BITS-1:0] row;
		gen_row_t            e;
		row = row_in & grid_mask();
		if (row_pending) begin
			e.next_row = next_generation(row_above, row_held, row);
			if (e.next_row != '0) any_live_seen = 1'b1;
			e.last_of_frame = 1'b0;
			e.frame_alive = 1'b0;
			expected_rows.push_back(e);
			row_above = row_held;
		end else begin
			row_above = '0;
		end
		row_held = row;
		row_pending = 1'b1;
		if (last) begin
			e.next_row = next_generation(row_above, row_held, '0);
			if (e.next_row != '0) any_live_seen = 1'b1;
			e.last_of_frame = 1'b1;
			e.frame_alive = any_live_seen;
			expected_rows.push_back(e);
			row_above = '0;
			row_held = '0;
			row_pending = 1'b0;
			any_live_seen = 1'b0;
		end
	endtask

	task automatic report_field(input string field, input logic [ROW_BITS-1:0] want,
			input logic [ROW_BITS-1:0] got);
		fail_count++;
		if (shown < SHOW_LIMIT) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
		end
		shown++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		gen_row_t want;
		if (!arst_n) begin
			birth_mask = BIRTH_MASK_RST;
			survive_mask = SURVIVE_MASK_RST;
			columns = COLUMNS_RST;
			row_above = '0;
			row_held = '0;
			row_pending = 1'b0;
			any_live_seen = 1'b0;
			expected_rows.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			// Track register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BIRTH_MASK: birth_mask = cfg_data;
					REG_SURVIVE_MASK: survive_mask = cfg_data;
					REG_COLUMNS: columns = cfg_data[COL_BITS-1:0];
					default: ;
				endcase
			end
			// Compare each result word with the oldest expectation
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_rows.size() == 0) begin
					fail_count++;
					if (shown < SHOW_LIMIT) begin
						$display("%0t: result word, expected none, got %h last %b alive %b",
							$time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
					end
					shown++;
				end else begin
					want = expected_rows.pop_front();
					if (m_axis_tdata !== want.next_row)
						report_field("next_row", want.next_row, m_axis_tdata);
					if (m_axis_tlast !== want.last_of_frame)
						report_field("last_of_frame", ROW_BITS'(want.last_of_frame),
							ROW_BITS'(m_axis_tlast));
					if (m_axis_tuser !== want.frame_alive)
						report_field("frame_alive", ROW_BITS'(want.frame_alive),
							ROW_BITS'(m_axis_tuser));
				end
			end
			// Predict from each accepted row word
			if (s_axis_tvalid && s_axis_tready) take_row(s_axis_tdata, s_axis_tlast);
			pending <= expected_rows.size();
		end
	end

endmodule

/* tb/sv/life_like_automaton_step_unit_tb.sv */
// Testbench top: drives rows and register writes into the step unit and gives the verdict.
module life_like_automaton_step_unit_tb;
	import lla_pkg::*;

	localparam int         HALF_PERIOD   = 6;
	localparam logic [1:0] REG_UNUSED    = 2'd3;
	localparam int         SETTLE_CYCLES = 8;
	localparam int         HOLD_CYCLES   = 300;
	localparam int         QUIET_LIMIT   = 2000;
	localparam int         PHASE_ROWS    = 430;
	localparam int         CFG_EVERY     = 120;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [ROW_BITS-1:0]  s_axis_tdata  = '0;  // [63:0] row_cells
	logic                 s_axis_tlast  = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [ROW_BITS-1:0]  m_axis_tdata;        // [63:0] next_row
	logic                 m_axis_tlast;
	logic                 m_axis_tuser;        // [0] frame_alive
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [1:0]           cfg_index     = '0;
	logic [MASK_BITS-1:0] cfg_data      = '0;

	int fail_count;
	int pending;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;

	life_like_automaton_step_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	lla_step_checker step_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		forever #HALF_PERIOD clk = ~clk;
	end

	// Result side: stall at random, or hold off for a long stretch on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left <= 0;
			hold_served <= 0;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_served + 1;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Drop the run when no word moves on any channel for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("life_like_automaton_step_unit_tb: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one row word after a random gap and hold it until taken
	task automatic send_row(input logic [ROW_BITS-1:0] row, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= row;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [MASK_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stop sending, let every owed result arrive, then let the block settle
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [ROW_BITS-1:0] pick_row();
		case ($urandom_range(0, 6))
			0: return '0;
			1: return '1;
			2: return {$urandom, $urandom} & {$urandom, $urandom};
			3: return {$urandom, $urandom} | {$urandom, $urandom};
			4: return 64'h7 << $urandom_range(0, 61);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [MASK_BITS-1:0] pick_mask(input logic [MASK_BITS-1:0] usual);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return usual;
			default: return MASK_BITS'($urandom_range(0, 511));
		endcase
	endfunction

	task automatic write_random_config();
		int cols;
		write_reg(REG_BIRTH_MASK, pick_mask(BIRTH_MASK_RST));
		write_reg(REG_SURVIVE_MASK, pick_mask(SURVIVE_MASK_RST));
		case ($urandom_range(0, 7))
			0: cols = 0;
			1: cols = 1;
			2: cols = 64;
			3: cols = $urandom_range(65, 127);
			4: cols = 3;
			default: cols = $urandom_range(1, 64);
		endcase
		// upper data bits lie outside the width register and must be dropped
		write_reg(REG_COLUMNS, {2'($urandom_range(0, 3)), 7'(cols)});
		if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, MASK_BITS'($urandom));
	endtask

	task automatic send_frame(input int rows);
		int r;
		for (r = 0; r < rows; r++) send_row(pick_row(), r == rows - 1);
	endtask

	// One stretch of random frames under one idling pattern
	task automatic run_phase(input int send_pct, input int recv_pct, input int rows_total,
			input bit hold_off);
		int sent;
		int since_cfg;
		int frame_rows;
		send_idle_pct = send_pct;
		recv_idle_pct <= recv_pct;
		sent = 0;
		since_cfg = 0;
		wait_idle();
		write_random_config();
		if (hold_off) begin
			// keep offering rows while the result side is held off
			hold_requests <= hold_requests + 1;
			send_frame(40);
			sent = 40;
		end
		while (sent < rows_total) begin
			if (since_cfg >= CFG_EVERY) begin
				wait_idle();
				write_random_config();
				since_cfg = 0;
			end else if ($urandom_range(0, 19) == 0) begin
				wait_idle();
			end
			frame_rows = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 12);
			send_frame(frame_rows);
			sent += frame_rows;
			since_cfg += frame_rows;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset rule: single-row frame of all live cells, then edge patterns
		send_row('1, 1'b1);
		send_row('0, 1'b0);
		send_row('1, 1'b0);
		send_row({32{2'b10}}, 1'b0);
		send_row({32{2'b01}}, 1'b1);
		// blinkers against the low grid edge and one cell in from the high edge
		send_row('0, 1'b0);
		send_row(64'h7000_0000_0000_0007, 1'b0);
		send_row('0, 1'b1);

		// All birth counts enabled and no survival counts, one column wide
		wait_idle();
		write_reg(REG_BIRTH_MASK, '1);
		write_reg(REG_SURVIVE_MASK, '0);
		write_reg(REG_COLUMNS, 9'd1);
		send_row('1, 1'b0);
		send_row('1, 1'b1);

		// Zero width, given with stray upper data bits
		wait_idle();
		write_reg(REG_COLUMNS, 9'h180);
		send_row({$urandom, $urandom}, 1'b0);
		send_row({$urandom, $urandom}, 1'b1);

		// Width beyond the limit
		wait_idle();
		write_reg(REG_BIRTH_MASK, '0);
		write_reg(REG_SURVIVE_MASK, '1);
		write_reg(REG_COLUMNS, 9'd127);
		send_row({$urandom, $urandom}, 1'b0);
		send_row({$urandom, $urandom}, 1'b1);

		// Narrow grid with input bits beyond the width
		wait_idle();
		write_reg(REG_BIRTH_MASK, 9'h1FE);
		write_reg(REG_SURVIVE_MASK, '1);
		write_reg(REG_COLUMNS, 9'd3);
		send_row('1, 1'b0);
		send_row('1, 1'b0);
		send_row('1, 1'b1);

		// Unused index, then a rule change in the middle of a frame
		wait_idle();
		write_reg(REG_UNUSED, '1);
		write_reg(REG_BIRTH_MASK, BIRTH_MASK_RST);
		write_reg(REG_SURVIVE_MASK, SURVIVE_MASK_RST);
		write_reg(REG_COLUMNS, 9'(COLUMNS_RST));
		send_row({$urandom, $urandom}, 1'b0);
		wait_idle();
		write_reg(REG_BIRTH_MASK, 9'h0C6);
		send_row({$urandom, $urandom}, 1'b0);
		send_row({$urandom, $urandom}, 1'b1);
		send_row('0, 1'b1);

		run_phase(27, 86, PHASE_ROWS, 1'b0);
		run_phase(86, 27, PHASE_ROWS, 1'b0);
		run_phase(0, 0, PHASE_ROWS, 1'b1);

		wait_idle();
		if (fail_count == 0) begin
			$display("life_like_automaton_step_unit_tb: PASS");
		end else begin
			$display("life_like_automaton_step_unit_tb: FAIL");
		end
		$finish;
	end

endmodule
